@@ rtl/core/lidar_weighted_distance_smoother_assert.svh @@
// Assertion macros for the range smoother checker.
`ifndef LIDAR_WEIGHTED_DISTANCE_SMOOTHER_ASSERT_SVH
`define LIDAR_WEIGHTED_DISTANCE_SMOOTHER_ASSERT_SVH
// same-cycle implication on clk_i, off during reset
`define LWDS_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication on clk_i, off during reset
`define LWDS_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`endif

@@ rtl/core/lwds_pkg.sv @@
// Package of the range smoother: types, register indexes, microcode.
`default_nettype none
package lwds_pkg;

  localparam int unsigned DistBitsDef = 16;
  localparam int unsigned FracBitsDef = 8;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned WgtW     = 17;
  localparam int unsigned NearW    = 15;
  localparam int unsigned PcW      = 4;
  localparam int unsigned DivCntW  = 5;

  localparam logic [WgtW-1:0]    OneQ16      = 17'h10000;
  localparam logic [15:0]        OneQ15      = 16'h8000;
  localparam logic [15:0]        PitchBase   = 16'hC000;
  localparam logic [DivCntW-1:0] WgtDivSteps = 5'd17;
  localparam logic [DivCntW-1:0] MapDivSteps = 5'd15;

  localparam logic [CfgIdxW-1:0] RegMaxSmooth = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNoiseDist = 3'd1;
  localparam logic [CfgIdxW-1:0] RegNearDist  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegFarDist   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegWeakSig   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStrongSig = 3'd5;
  localparam logic [CfgIdxW-1:0] RegFloorWgt  = 3'd6;
  localparam logic [CfgIdxW-1:0] RegPitchMode = 3'd7;

  // microcode addresses used as jump targets
  localparam logic [PcW-1:0] PcLoad   = 4'd0;
  localparam logic [PcW-1:0] PcSigDiv = 4'd2;
  localparam logic [PcW-1:0] PcWgtLd  = 4'd4;
  localparam logic [PcW-1:0] PcWgtDiv = 4'd5;
  localparam logic [PcW-1:0] PcMapDiv = 4'd11;
  localparam logic [PcW-1:0] PcOut    = 4'd13;

  typedef struct packed {
    logic [15:0] raw_distance;
    logic [7:0]  signal_strength;
  } lwds_in_t;

  typedef struct packed {
    logic [15:0] smoothed_distance;
    logic [15:0] control_level;
    logic        noise_sample;
  } lwds_out_t;

  typedef struct packed {
    logic [7:0]       max_smooth_samples;
    logic [15:0]      noise_distance;
    logic [NearW-1:0] near_distance;
    logic [NearW-1:0] far_distance;
    logic [7:0]       weak_signal;
    logic [7:0]       strong_signal;
    logic [15:0]      floor_weight;
    logic             pitch_mode;
  } lwds_cfg_t;

  typedef enum logic [3:0] {
    OP_NOP, OP_LOAD, OP_SMAP, OP_DIV, OP_SMAP_END, OP_WDIV, OP_W_END,
    OP_MUL_A, OP_MUL_B, OP_UPD, OP_DMAP, OP_DMAP_END, OP_OUT
  } lwds_op_e;

  typedef enum logic [2:0] {
    JC_NEXT, JC_ALWAYS, JC_NO_IN, JC_DIV_BUSY, JC_SKIP, JC_OUT_FULL
  } lwds_jc_e;

  typedef struct packed {
    lwds_op_e       op;
    lwds_jc_e       jc;
    logic [PcW-1:0] target;
  } lwds_uword_t;

  typedef struct packed {
    logic in_fire;
    logic div_last;
    logic skip;
    logic out_full;
  } lwds_stat_t;

  function automatic lwds_uword_t lwds_ucode(input logic [PcW-1:0] pc);
    lwds_uword_t w;
    unique case (pc)
      4'd0:    w = '{op: OP_LOAD,     jc: JC_NO_IN,    target: PcLoad};
      4'd1:    w = '{op: OP_SMAP,     jc: JC_SKIP,     target: PcWgtLd};
      4'd2:    w = '{op: OP_DIV,      jc: JC_DIV_BUSY, target: PcSigDiv};
      4'd3:    w = '{op: OP_SMAP_END, jc: JC_NEXT,     target: PcLoad};
      4'd4:    w = '{op: OP_WDIV,     jc: JC_NEXT,     target: PcLoad};
      4'd5:    w = '{op: OP_DIV,      jc: JC_DIV_BUSY, target: PcWgtDiv};
      4'd6:    w = '{op: OP_W_END,    jc: JC_NEXT,     target: PcLoad};
      4'd7:    w = '{op: OP_MUL_A,    jc: JC_NEXT,     target: PcLoad};
      4'd8:    w = '{op: OP_MUL_B,    jc: JC_NEXT,     target: PcLoad};
      4'd9:    w = '{op: OP_UPD,      jc: JC_NEXT,     target: PcLoad};
      4'd10:   w = '{op: OP_DMAP,     jc: JC_SKIP,     target: PcOut};
      4'd11:   w = '{op: OP_DIV,      jc: JC_DIV_BUSY, target: PcMapDiv};
      4'd12:   w = '{op: OP_DMAP_END, jc: JC_NEXT,     target: PcLoad};
      4'd13:   w = '{op: OP_OUT,      jc: JC_OUT_FULL, target: PcOut};
      default: w = '{op: OP_NOP,      jc: JC_ALWAYS,   target: PcLoad};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/lidar_weighted_distance_smoother.sv @@
// Top level of the signal-weighted range smoother.
// One range word in, one result word out. Each word runs through a short
// microcode program on one shared multiplier and one radix-2 divider: the
// signal map, the weight divide by the sample count and the distance map
// take 17, 17 and 15 divider steps. The signal-map divide is skipped for
// a noise word or a clamped strength, and the distance-map divide when
// the map clamps. A result waits in the output register, and the next
// word is taken meanwhile; the program holds at its write-back step only
// while an older result is still not taken, which delays the next accept.
// Configuration writes are taken in any cycle and belong in idle
// periods. There is no clearing pass after reset.
`default_nettype none
module lidar_weighted_distance_smoother #(
  parameter int unsigned DIST_BITS = lwds_pkg::DistBitsDef,
  parameter int unsigned FRAC_BITS = lwds_pkg::FracBitsDef
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire  [lwds_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [lwds_pkg::CfgDataW-1:0] cfg_data_i,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  lwds_pkg::lwds_in_t            in_data_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output lwds_pkg::lwds_out_t           out_data_o
);
  import lwds_pkg::*;

  lwds_cfg_t   cfg_q;
  lwds_uword_t uword;
  lwds_stat_t  stat;
  lwds_out_t   res, out_q;
  logic        out_valid_q;
  logic        in_fire, out_full, out_load, skip, div_last;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = uword.op == OP_LOAD;
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_full    = out_valid_q & ~out_ready_i;
  assign out_load    = (uword.op == OP_OUT) & ~out_full;

  assign stat = '{in_fire: in_fire, div_last: div_last, skip: skip, out_full: out_full};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_smooth_samples <= 8'd1;
      cfg_q.noise_distance     <= 16'd20;
      cfg_q.near_distance      <= 15'd30;
      cfg_q.far_distance       <= 15'd600;
      cfg_q.weak_signal        <= 8'd20;
      cfg_q.strong_signal      <= 8'd80;
      cfg_q.floor_weight       <= 16'd3277;
      cfg_q.pitch_mode         <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegMaxSmooth: cfg_q.max_smooth_samples <= cfg_data_i[7:0];
        RegNoiseDist: cfg_q.noise_distance     <= cfg_data_i;
        RegNearDist:  cfg_q.near_distance      <= cfg_data_i[NearW-1:0];
        RegFarDist:   cfg_q.far_distance       <= cfg_data_i[NearW-1:0];
        RegWeakSig:   cfg_q.weak_signal        <= cfg_data_i[7:0];
        RegStrongSig: cfg_q.strong_signal      <= cfg_data_i[7:0];
        RegFloorWgt:  cfg_q.floor_weight       <= cfg_data_i;
        RegPitchMode: cfg_q.pitch_mode         <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  lwds_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stat_i  (stat),
    .uword_o (uword)
  );

  lwds_dp #(
    .DIST_BITS(DIST_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .op_i       (uword.op),
    .cfg_i      (cfg_q),
    .in_data_i  (in_data_i),
    .in_fire_i  (in_fire),
    .skip_o     (skip),
    .div_last_o (div_last),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

@@ rtl/core/lwds_seq.sv @@
// Microcode sequencer: step counter, control store and jump logic.
`default_nettype none
module lwds_seq (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  lwds_pkg::lwds_stat_t stat_i,
  output lwds_pkg::lwds_uword_t uword_o
);
  import lwds_pkg::*;

  logic [PcW-1:0] pc_q, pc_d;
  lwds_uword_t    uw;
  logic           take;

  assign uw      = lwds_ucode(pc_q);
  assign uword_o = uw;

  always_comb begin
    unique case (uw.jc)
      JC_NEXT:     take = 1'b0;
      JC_ALWAYS:   take = 1'b1;
      JC_NO_IN:    take = !stat_i.in_fire;
      JC_DIV_BUSY: take = !stat_i.div_last;
      JC_SKIP:     take = stat_i.skip;
      JC_OUT_FULL: take = stat_i.out_full;
      default:     take = 1'b0;
    endcase
    pc_d = take ? uw.target : pc_q + PcW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PcLoad;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lwds_div.sv @@
// Shared radix-2 restoring divider, one quotient bit per step.
`default_nettype none
module lwds_div #(
  parameter int unsigned RemW = 23
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            load_i,
  input  wire                            step_i,
  input  wire  [RemW-1:0]                rem_init_i,
  input  wire  [lwds_pkg::WgtW-1:0]      quo_init_i,
  input  wire  [RemW-1:0]                div_i,
  input  wire  [lwds_pkg::DivCntW-1:0]   cnt_init_i,
  output logic [lwds_pkg::WgtW-1:0]      quo_o,
  output logic                           last_o
);
  import lwds_pkg::*;

  logic [RemW-1:0]    rem_q;
  logic [WgtW-1:0]    quo_q;
  logic [RemW-1:0]    div_q;
  logic [DivCntW-1:0] cnt_q;
  logic [RemW:0]      trial, diff;
  logic               ge;

  assign trial  = {rem_q, quo_q[WgtW-1]};
  assign diff   = trial - {1'b0, div_q};
  assign ge     = trial >= {1'b0, div_q};
  assign quo_o  = quo_q;
  assign last_o = cnt_q == DivCntW'(1);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rem_q <= rem_init_i;
      quo_q <= quo_init_i;
      div_q <= div_i;
    end else if (step_i) begin
      rem_q <= ge ? diff[RemW-1:0] : trial[RemW-1:0];
      quo_q <= {quo_q[WgtW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= cnt_init_i;
    end else if (step_i) begin
      cnt_q <= cnt_q - DivCntW'(1);
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/lwds_dp.sv @@
// Datapath of the range smoother: weights, blend, distance map.
`default_nettype none
module lwds_dp #(
  parameter int unsigned DIST_BITS = lwds_pkg::DistBitsDef,
  parameter int unsigned FRAC_BITS = lwds_pkg::FracBitsDef
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  lwds_pkg::lwds_op_e    op_i,
  input  lwds_pkg::lwds_cfg_t   cfg_i,
  input  lwds_pkg::lwds_in_t    in_data_i,
  input  wire                   in_fire_i,
  output logic                  skip_o,
  output logic                  div_last_o,
  output lwds_pkg::lwds_out_t   res_o
);
  import lwds_pkg::*;

  localparam int unsigned SB    = DIST_BITS + FRAC_BITS;
  localparam int unsigned RemW  = NearW + FRAC_BITS;
  localparam int unsigned LW    = ((SB > RemW) ? SB : RemW) + 1;
  localparam int unsigned NvW   = (DIST_BITS > 16) ? DIST_BITS : 16;
  localparam int unsigned ProdW = SB + WgtW;
  localparam logic [NvW-1:0] DistMax = NvW'((64'd1 << DIST_BITS) - 64'd1);

  logic                 noisy_q, noisy_d;
  logic [DIST_BITS-1:0] nv_q, nv_d;
  logic [7:0]           sig_q, sig_d;
  logic [7:0]           cnt_q, cnt_d;
  logic [WgtW-1:0]      fac_q, fac_d;
  logic [WgtW-1:0]      w_q, w_d;
  logic [15:0]          m_q, m_d;
  logic [SB-1:0]        s_q, s_d;
  logic [ProdW-1:0]     acc_q, acc_d;
  logic [ProdW-1:0]     prod_q, prod_d;

  logic [SB-1:0]        mul_a;
  logic [WgtW-1:0]      mul_b;
  logic [ProdW-1:0]     prod;

  logic                 in_noisy;
  logic [15:0]          cand;
  logic [NvW-1:0]       nv_wide;

  logic [8:0]           sig_t, sig_d9;
  logic [7:0]           s_at, s_ad;
  logic [WgtW-1:0]      span;
  logic                 s_degen;

  logic [LW-1:0]        t, d, at, ad;
  logic                 d_degen;
  logic [ProdW:0]       sum;
  logic [7:0]           cnt_eff;

  logic                 div_load;
  logic [RemW-1:0]      div_rem, div_div;
  logic [WgtW-1:0]      div_quo_init, div_quo;
  logic [DivCntW-1:0]   div_cnt;

  assign prod = ProdW'(mul_a) * ProdW'(mul_b);

  assign in_noisy = in_data_i.raw_distance < cfg_i.noise_distance;
  assign cand     = in_noisy ? {cfg_i.far_distance, 1'b0} : in_data_i.raw_distance;
  assign nv_wide  = NvW'(cand);

  assign sig_t   = {1'b0, sig_q} - {1'b0, cfg_i.weak_signal};
  assign sig_d9  = {1'b0, cfg_i.strong_signal} - {1'b0, cfg_i.weak_signal};
  assign s_at    = sig_t[8] ? 8'(-sig_t) : sig_t[7:0];
  assign s_ad    = sig_d9[8] ? 8'(-sig_d9) : sig_d9[7:0];
  assign span    = OneQ16 - {1'b0, cfg_i.floor_weight};
  assign s_degen = (sig_d9 == '0) || (sig_t == '0) || (sig_t[8] != sig_d9[8]);

  assign t  = LW'(s_q) - LW'({cfg_i.near_distance, {FRAC_BITS{1'b0}}});
  assign d  = LW'({cfg_i.far_distance, {FRAC_BITS{1'b0}}})
            - LW'({cfg_i.near_distance, {FRAC_BITS{1'b0}}});
  assign at = t[LW-1] ? -t : t;
  assign ad = d[LW-1] ? -d : d;
  assign d_degen = (d == '0) || (t == '0) || (t[LW-1] != d[LW-1]);

  assign sum     = {1'b0, acc_q} + {1'b0, prod_q};
  assign cnt_eff = (cnt_q == 8'd0) ? 8'd1 : cnt_q;

  always_comb begin
    noisy_d      = noisy_q;
    nv_d         = nv_q;
    sig_d        = sig_q;
    cnt_d        = cnt_q;
    fac_d        = fac_q;
    w_d          = w_q;
    m_d          = m_q;
    s_d          = s_q;
    acc_d        = acc_q;
    prod_d       = prod_q;
    mul_a        = s_q;
    mul_b        = OneQ16 - w_q;
    skip_o       = 1'b0;
    div_load     = 1'b0;
    div_rem      = '0;
    div_quo_init = '0;
    div_div      = RemW'(cnt_eff);
    div_cnt      = WgtDivSteps;
    unique case (op_i)
      OP_LOAD: begin
        if (in_fire_i) begin
          noisy_d = in_noisy;
          sig_d   = in_data_i.signal_strength;
          nv_d    = (nv_wide > DistMax) ? DistMax[DIST_BITS-1:0] : nv_wide[DIST_BITS-1:0];
          if (cnt_q < cfg_i.max_smooth_samples) begin
            cnt_d = cnt_q + 8'd1;
          end
        end
      end
      OP_SMAP: begin
        mul_a = SB'(s_at);
        mul_b = span;
        skip_o = 1'b1;
        if (noisy_q) begin
          fac_d = span;
        end else if (s_degen) begin
          fac_d = {1'b0, cfg_i.floor_weight};
        end else if (s_at >= s_ad) begin
          fac_d = OneQ16;
        end else begin
          skip_o       = 1'b0;
          div_load     = 1'b1;
          div_rem      = RemW'(prod[24:17]);
          div_quo_init = prod[16:0];
          div_div      = RemW'(s_ad);
        end
      end
      OP_SMAP_END: fac_d = {1'b0, cfg_i.floor_weight} + div_quo;
      OP_WDIV: begin
        div_load     = 1'b1;
        div_quo_init = fac_q;
      end
      OP_W_END: w_d = div_quo;
      OP_MUL_A: acc_d = prod;
      OP_MUL_B: begin
        mul_a  = {nv_q, {FRAC_BITS{1'b0}}};
        mul_b  = w_q;
        prod_d = prod;
      end
      OP_UPD: s_d = sum[16 +: SB];
      OP_DMAP: begin
        skip_o = 1'b1;
        if (d_degen) begin
          m_d = '0;
        end else if (at >= ad) begin
          m_d = OneQ15;
        end else begin
          skip_o   = 1'b0;
          div_load = 1'b1;
          div_rem  = at[RemW-1:0];
          div_div  = ad[RemW-1:0];
          div_cnt  = MapDivSteps;
        end
      end
      OP_DMAP_END: m_d = {1'b0, div_quo[14:0]};
      default: ;
    endcase
  end

  lwds_div #(
    .RemW(RemW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (div_load),
    .step_i     (op_i == OP_DIV),
    .rem_init_i (div_rem),
    .quo_init_i (div_quo_init),
    .div_i      (div_div),
    .cnt_init_i (div_cnt),
    .quo_o      (div_quo),
    .last_o     (div_last_o)
  );

  always_ff @(posedge clk_i) begin
    noisy_q <= noisy_d;
    nv_q    <= nv_d;
    sig_q   <= sig_d;
    fac_q   <= fac_d;
    w_q     <= w_d;
    m_q     <= m_d;
    acc_q   <= acc_d;
    prod_q  <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      s_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      s_q   <= s_d;
    end
  end

  assign res_o.smoothed_distance = 16'(s_q >> FRAC_BITS);
  assign res_o.control_level     = (cfg_i.pitch_mode ? PitchBase : OneQ15) - m_q;
  assign res_o.noise_sample      = noisy_q;

endmodule
`default_nettype wire

@@ rtl/core/lwds_chk.sv @@
// Port checker of the range smoother and its bind to the top level.
`default_nettype none
`include "lidar_weighted_distance_smoother_assert.svh"
module lwds_chk (
  input wire                           clk_i,
  input wire                           rst_ni,
  input wire                           in_valid_i,
  input wire                           in_ready_o,
  input wire                           out_valid_o,
  input wire                           out_ready_i,
  input lwds_pkg::lwds_out_t           out_data_o
);

  // a stalled result word holds
  `LWDS_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result word changed while stalled")

  // one word in flight: no new word right after an accept
  `LWDS_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_o, !in_ready_o, "input taken twice in a row")

  // no result can follow an accept in the next cycle
  `LWDS_ASSERT_NXT(a_no_instant_result, in_valid_i && in_ready_o && !out_valid_o, !out_valid_o, "result appeared right after accept")

  // a new result shows up only while the sequencer is busy
  `LWDS_ASSERT_IMP(a_result_while_busy, $rose(out_valid_o), !in_ready_o, "result appeared while input ready")

endmodule

bind lidar_weighted_distance_smoother lwds_chk u_lwds_chk (.*);
`default_nettype wire
